### src/stt_pkg.sv
// Package for the source text tokenizer.
// Holds the scan modes, result kinds, byte codes and the result beat type.
// No dependencies.
package stt_pkg;

    // Default counter width for row, column, offset and length
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // Result queue depth; one accepted beat pushes at most two results
    localparam int unsigned RES_DEPTH = 4;

    // Byte codes that steer the scan
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SEMI    = 8'h3B;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WORD = 3'd1,
        MODE_STR  = 3'd2,
        MODE_CMT  = 3'd3,
        MODE_ERR  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_WORD = 2'd0,
        KIND_STR  = 2'd1,
        KIND_ERR  = 2'd2,
        KIND_END  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start_offset;
        logic [15:0] row;
        logic [15:0] column;
        logic [15:0] length;
        logic        last;
    } t_result;

endpackage

### src/source_text_tokenizer.sv
// Source text tokenizer top level.
// Scan state machine and a small result queue; depends on stt_pkg.
// Takes one byte (or an end marker) per beat and gives tokens with position.
//
// The block takes one byte beat per clock cycle while o_stall is low. Each
// byte is decoded in the cycle it is accepted, against the registered scan
// state, and its results go straight into a four-entry result queue. A byte
// gives at most one result; the end marker gives up to two (an open word or
// an unclosed string, then the end result). The input is stalled only while
// the queue holds more than two results, so with the output side taking a
// beat every cycle the block sustains one byte per cycle. Row, column, offset
// and length counters are COUNT_WIDTH bits and saturate; reported values above
// 65535 read as 65535. After the end marker all scan state returns to its
// reset values for the next text.
module source_text_tokenizer #(
    parameter int unsigned COUNT_WIDTH = stt_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte beats in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_text,
    // result beats out
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_row,
    output logic [15:0] o_column,
    output logic [15:0] o_length,
    output logic        o_last
);
    import stt_pkg::*;

    localparam int unsigned PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);
    localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

    // Saturating increment of a counter
    function automatic logic [COUNT_WIDTH-1:0] f_sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + ONE;
    endfunction

    // Clamp a counter to the 16-bit result field
    function automatic logic [15:0] f_out16(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+15:0] wide;
        wide = {16'b0, v};
        if (wide > (COUNT_WIDTH + 16)'(16'hFFFF)) begin
            return 16'hFFFF;
        end
        return wide[15:0];
    endfunction

    // Scan state
    t_mode                  r_mode, n_mode;
    logic [COUNT_WIDTH-1:0] r_cur_row, n_cur_row;
    logic [COUNT_WIDTH-1:0] r_cur_col, n_cur_col;
    logic [COUNT_WIDTH-1:0] r_position, n_position;
    logic [COUNT_WIDTH-1:0] r_tok_start, n_tok_start;
    logic [COUNT_WIDTH-1:0] r_tok_row, n_tok_row;
    logic [COUNT_WIDTH-1:0] r_tok_col, n_tok_col;
    logic [COUNT_WIDTH-1:0] r_tok_len, n_tok_len;

    // Result queue
    t_result            r_queue [RES_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    logic      in_accept;
    logic      out_accept;
    logic      to_idle;
    logic [1:0] push_cnt;
    t_result   res_a, res_b;

    assign in_accept  = i_valid && !o_stall;
    assign out_accept = o_valid && !i_stall;

    // Hold the input off while fewer than two queue slots are free
    assign o_stall = (r_count > CNT_W'(RES_DEPTH - 2));
    assign o_valid = (r_count != '0);

    // Decode one beat against the scan state
    always_comb begin
        n_mode      = r_mode;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_position  = r_position;
        n_tok_start = r_tok_start;
        n_tok_row   = r_tok_row;
        n_tok_col   = r_tok_col;
        n_tok_len   = r_tok_len;
        to_idle     = 1'b0;
        push_cnt    = 2'd0;

        res_a = '{kind: KIND_WORD, start_offset: f_out16(r_tok_start),
                  row: f_out16(r_tok_row), column: f_out16(r_tok_col),
                  length: f_out16(r_tok_len), last: 1'b1};
        res_b = '{kind: KIND_END, start_offset: 16'd0,
                  row: f_out16(r_cur_row), column: f_out16(r_cur_col),
                  length: 16'd0, last: 1'b1};

        if (i_end_of_text) begin
            // flush an open token, close with the end result, then reset
            case (r_mode)
                MODE_WORD: begin
                    res_a.last = 1'b0;
                    push_cnt   = 2'd2;
                end
                MODE_STR: begin
                    res_a.kind   = KIND_ERR;
                    res_a.length = 16'd0;
                    res_a.last   = 1'b0;
                    push_cnt     = 2'd2;
                end
                default: begin
                    res_a    = res_b;
                    push_cnt = 2'd1;
                end
            endcase
            n_mode      = MODE_IDLE;
            n_cur_row   = ONE;
            n_cur_col   = ONE;
            n_position  = '0;
            n_tok_start = '0;
            n_tok_row   = ONE;
            n_tok_col   = ONE;
            n_tok_len   = '0;
        end else begin
            unique case (r_mode)
                MODE_WORD: begin
                    if (i_ch == CH_SPACE || i_ch == CH_NEWLINE || i_ch == CH_SEMI) begin
                        push_cnt = 2'd1;
                        n_mode   = MODE_IDLE;
                        to_idle  = 1'b1;
                    end else begin
                        n_tok_len = f_sat_inc(r_tok_len);
                        n_cur_col = f_sat_inc(r_cur_col);
                    end
                end
                MODE_STR: begin
                    if (i_ch == CH_NEWLINE) begin
                        res_a.kind   = KIND_ERR;
                        res_a.length = 16'd0;
                        push_cnt     = 2'd1;
                        n_mode       = MODE_ERR;
                    end else begin
                        n_tok_len = f_sat_inc(r_tok_len);
                        n_cur_col = f_sat_inc(r_cur_col);
                        if (i_ch == CH_QUOTE) begin
                            res_a.kind   = KIND_STR;
                            res_a.length = f_out16(n_tok_len);
                            push_cnt     = 2'd1;
                            n_mode       = MODE_IDLE;
                        end
                    end
                end
                MODE_CMT: begin
                    if (i_ch == CH_NEWLINE) begin
                        n_mode    = MODE_IDLE;
                        n_cur_row = f_sat_inc(r_cur_row);
                        n_cur_col = ONE;
                    end else begin
                        n_cur_col = f_sat_inc(r_cur_col);
                    end
                end
                MODE_ERR: begin
                    // drop bytes until the end marker
                end
                default: begin
                    to_idle = 1'b1;
                end
            endcase

            // Between tokens, also for the byte that ends a word
            if (to_idle) begin
                if (i_ch == CH_NEWLINE) begin
                    n_cur_row = f_sat_inc(r_cur_row);
                    n_cur_col = ONE;
                end else begin
                    if (i_ch == CH_SEMI) begin
                        n_mode = MODE_CMT;
                    end else if (i_ch != CH_SPACE) begin
                        n_mode      = (i_ch == CH_QUOTE) ? MODE_STR : MODE_WORD;
                        n_tok_start = r_position;
                        n_tok_row   = r_cur_row;
                        n_tok_col   = r_cur_col;
                        n_tok_len   = ONE;
                    end
                    n_cur_col = f_sat_inc(r_cur_col);
                end
            end

            n_position = f_sat_inc(r_position);
        end
    end

    // Advance the scan state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_cur_row   <= ONE;
            r_cur_col   <= ONE;
            r_position  <= '0;
            r_tok_start <= '0;
            r_tok_row   <= ONE;
            r_tok_col   <= ONE;
            r_tok_len   <= '0;
        end else if (in_accept) begin
            r_mode      <= n_mode;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_position  <= n_position;
            r_tok_start <= n_tok_start;
            r_tok_row   <= n_tok_row;
            r_tok_col   <= n_tok_col;
            r_tok_len   <= n_tok_len;
        end
    end

    // Queue occupancy after this cycle's push and pop
    always_comb begin
        n_count = r_count;
        if (in_accept) begin
            n_count = n_count + CNT_W'(push_cnt);
        end
        if (out_accept) begin
            n_count = n_count - CNT_W'(1);
        end
    end

    // Queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (in_accept) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(push_cnt);
            end
            if (out_accept) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // Queue storage: write up to two results per accepted beat
    always_ff @(posedge i_clk) begin
        if (in_accept && push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res_a;
            if (push_cnt == 2'd2) begin
                r_queue[r_wr_ptr + PTR_W'(1)] <= res_b;
            end
        end
    end

    // Drive the head result
    assign o_kind         = r_queue[r_rd_ptr].kind;
    assign o_start_offset = r_queue[r_rd_ptr].start_offset;
    assign o_row          = r_queue[r_rd_ptr].row;
    assign o_column       = r_queue[r_rd_ptr].column;
    assign o_length       = r_queue[r_rd_ptr].length;
    assign o_last         = r_queue[r_rd_ptr].last;

    // Queue never overfills
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RES_DEPTH))
        else $error("result queue overfilled");

    // Only the end marker gives two results
    a_two_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && push_cnt == 2'd2 |-> i_end_of_text)
        else $error("two results from a text byte");

    // An end result always closes its beat group
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_END |-> o_last)
        else $error("end result without last");

    // The end marker returns the scan to its reset state
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_end_of_text |=> r_mode == MODE_IDLE && r_position == '0
            && r_cur_row == ONE && r_cur_col == ONE)
        else $error("scan state not cleared after end marker");

    // Error mode drops bytes without results
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_end_of_text && r_mode == MODE_ERR |-> push_cnt == 2'd0)
        else $error("result produced while dropping bytes");

endmodule

### tb/tb.sv
// Testbench for source_text_tokenizer: drives byte and end-marker beats, predicts tokens.
// Holds the token scoreboard class, the drive tasks and the result monitor.
// Depends on stt_pkg and the source_text_tokenizer top level.
`timescale 1ns / 1ps

module tb;
    import stt_pkg::*;

    // Generous bound on the run
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned RANDOM_ITEMS = 1300;
    // Long enough to push row, column, offset and length past 65535
    localparam int unsigned SAT_RUN = 66000;
    localparam int unsigned TAIL_CYCLES = 16;

    typedef enum {RX_FREE, RX_LIGHT, RX_TOGGLE, RX_HEAVY} t_rx_pattern;
    typedef enum {SHAPE_WELL, SHAPE_BROKEN, SHAPE_NOISE} t_shape;

    // Tokenizer prediction and the queue of tokens still to arrive
    class tok_scoreboard;
        t_result     expected_q[$];
        int unsigned n_fail;
        t_mode       mode;
        logic [15:0] cur_row, cur_col, position, tok_start, tok_row, tok_col, tok_len;

        function new();
            n_fail = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode      = MODE_IDLE;
            cur_row   = 16'd1;
            cur_col   = 16'd1;
            position  = 16'd0;
            tok_start = 16'd0;
            tok_row   = 16'd1;
            tok_col   = 16'd1;
            tok_len   = 16'd0;
        endfunction

        // Saturating increment of a counter
        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function void emit(t_kind k, logic [15:0] off, logic [15:0] r, logic [15:0] c,
                           logic [15:0] len);
            t_result t;
            t.kind         = k;
            t.start_offset = off;
            t.row          = r;
            t.column       = c;
            t.length       = len;
            t.last         = 1'b0;
            expected_q.push_back(t);
        endfunction

        function void begin_token(t_mode m);
            mode      = m;
            tok_start = position;
            tok_row   = cur_row;
            tok_col   = cur_col;
            tok_len   = 16'd1;
        endfunction

        // Byte seen between tokens, including the one that closes a word
        function void scan_between(logic [7:0] c);
            if (c == CH_NEWLINE) begin
                cur_row = bump(cur_row);
                cur_col = 16'd1;
                return;
            end
            if (c == CH_QUOTE) begin
                begin_token(MODE_STR);
            end else if (c == CH_SEMI) begin
                mode = MODE_CMT;
            end else if (c != CH_SPACE) begin
                begin_token(MODE_WORD);
            end
            cur_col = bump(cur_col);
        endfunction

        // Note one accepted input beat and queue the tokens it causes
        function void note_byte(logic [7:0] c, logic eot);
            int unsigned before_n;
            before_n = expected_q.size();
            if (eot) begin
                if (mode == MODE_WORD) begin
                    emit(KIND_WORD, tok_start, tok_row, tok_col, tok_len);
                end else if (mode == MODE_STR) begin
                    emit(KIND_ERR, tok_start, tok_row, tok_col, 16'd0);
                end
                emit(KIND_END, 16'd0, cur_row, cur_col, 16'd0);
                clear_state();
            end else begin
                case (mode)
                    MODE_WORD: begin
                        if (c == CH_SPACE || c == CH_NEWLINE || c == CH_SEMI) begin
                            emit(KIND_WORD, tok_start, tok_row, tok_col, tok_len);
                            mode = MODE_IDLE;
                            scan_between(c);
                        end else begin
                            tok_len = bump(tok_len);
                            cur_col = bump(cur_col);
                        end
                    end
                    MODE_STR: begin
                        if (c == CH_NEWLINE) begin
                            emit(KIND_ERR, tok_start, tok_row, tok_col, 16'd0);
                            mode = MODE_ERR;
                        end else begin
                            tok_len = bump(tok_len);
                            cur_col = bump(cur_col);
                            if (c == CH_QUOTE) begin
                                emit(KIND_STR, tok_start, tok_row, tok_col, tok_len);
                                mode = MODE_IDLE;
                            end
                        end
                    end
                    MODE_CMT: begin
                        if (c == CH_NEWLINE) begin
                            mode    = MODE_IDLE;
                            cur_row = bump(cur_row);
                            cur_col = 16'd1;
                        end else begin
                            cur_col = bump(cur_col);
                        end
                    end
                    MODE_ERR: begin
                    end
                    default: begin
                        scan_between(c);
                    end
                endcase
                position = bump(position);
            end
            // Flag the final token of this beat
            if (expected_q.size() > before_n) begin
                expected_q[expected_q.size() - 1].last = 1'b1;
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                n_fail++;
            end
        endfunction

        // Check one accepted result beat against the oldest expected token
        function void check_token(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("result beat with none expected: kind %0d offset %0d row %0d",
                       got.kind, got.start_offset, got.row);
                n_fail++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", 16'(want.kind), 16'(got.kind));
            compare_field("start_offset", want.start_offset, got.start_offset);
            compare_field("row", want.row, got.row);
            compare_field("column", want.column, got.column);
            compare_field("length", want.length, got.length);
            compare_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic [7:0]  i_ch;
    logic        i_end_of_text;
    logic        i_stall;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [15:0] o_start_offset;
    logic [15:0] o_row;
    logic [15:0] o_column;
    logic [15:0] o_length;
    logic        o_last;

    tok_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned hold_req    = 0;
    bit          fast_mode   = 1'b0;

    source_text_tokenizer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ch           (i_ch),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_start_offset (o_start_offset),
        .o_row          (o_row),
        .o_column       (o_column),
        .o_length       (o_length),
        .o_last         (o_last)
    );

    // Free-running clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("run exceeded %0d cycles with %0d results outstanding",
                   CYCLE_LIMIT, sb.expected_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // Sample result beats at the rising edge
    always @(posedge i_clk) begin : result_monitor
        t_result beat;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            beat.kind         = t_kind'(o_kind);
            beat.start_offset = o_start_offset;
            beat.row          = o_row;
            beat.column       = o_column;
            beat.length       = o_length;
            beat.last         = o_last;
            sb.check_token(beat);
        end
    end

    // Receiver back-pressure: a long hold on request, otherwise rotating patterns
    initial begin : receiver
        t_rx_pattern pattern;
        int unsigned pat_left;
        int unsigned hold_left;
        pattern   = RX_FREE;
        pat_left  = 0;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                if (pat_left == 0) begin
                    pattern  = t_rx_pattern'($urandom_range(0, 3));
                    pat_left = $urandom_range(8, 80);
                end
                pat_left--;
                case (pattern)
                    RX_FREE:   i_stall <= 1'b0;
                    RX_LIGHT:  i_stall <= ($urandom_range(0, 99) < 30);
                    RX_TOGGLE: i_stall <= ~i_stall;
                    default:   i_stall <= ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    // Offer one beat and hold it until accepted; idle between bursts unless fast_mode is set
    task automatic send_beat(input logic [7:0] ch, input logic eot);
        int unsigned gap;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_ch          <= ch;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        // Bytes dropped after a broken string do not count as stimulus
        if (sb.mode != MODE_ERR || eot) begin
            items_sent++;
        end
        sb.note_byte(ch, eot);
        if (!fast_mode) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                  : $urandom_range(1, 3);
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_beat(s[i], 1'b0);
        end
    endtask

    task automatic send_end();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Drop the input, then wait until every expected result has arrived
    task automatic wait_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Random text byte, never a newline; delimiters and quotes are favoured
    function automatic logic [7:0] pick_text_byte(bit stop_delims, bit stop_quote);
        logic [7:0] b;
        do begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 2))
                    0:       b = CH_SPACE;
                    1:       b = CH_SEMI;
                    default: b = CH_QUOTE;
                endcase
            end else begin
                b = 8'($urandom_range(1, 255));
            end
        end while (b == CH_NEWLINE || (stop_delims && (b == CH_SPACE || b == CH_SEMI))
                   || (stop_quote && b == CH_QUOTE));
        return b;
    endfunction

    function automatic logic [7:0] pick_noise_byte();
        logic [7:0] b;
        if ($urandom_range(0, 99) < 40) begin
            case ($urandom_range(0, 3))
                0:       b = CH_SPACE;
                1:       b = CH_NEWLINE;
                2:       b = CH_QUOTE;
                default: b = CH_SEMI;
            endcase
        end else begin
            b = 8'($urandom_range(1, 255));
        end
        return b;
    endfunction

    // One text: mostly well formed, some broken strings, some plain noise
    task automatic send_random_text();
        t_shape      shape;
        int unsigned r;
        r = $urandom_range(0, 99);
        shape = (r < 75) ? SHAPE_WELL : (r < 88) ? SHAPE_BROKEN : SHAPE_NOISE;
        if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(4, 40)) send_beat(pick_noise_byte(), 1'b0);
        end else begin
            repeat ($urandom_range(1, 14)) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    // word; quotes may appear after the first byte
                    send_beat(pick_text_byte(1'b1, 1'b1), 1'b0);
                    repeat ($urandom_range(0, 7)) send_beat(pick_text_byte(1'b1, 1'b0), 1'b0);
                end else if (r < 52) begin
                    send_beat(CH_QUOTE, 1'b0);
                    repeat ($urandom_range(0, 6)) send_beat(pick_text_byte(1'b0, 1'b1), 1'b0);
                    send_beat(CH_QUOTE, 1'b0);
                end else if (r < 62) begin
                    send_beat(CH_SEMI, 1'b0);
                    repeat ($urandom_range(0, 8)) send_beat(pick_text_byte(1'b0, 1'b0), 1'b0);
                    send_beat(CH_NEWLINE, 1'b0);
                end else if (r < 80) begin
                    repeat ($urandom_range(1, 3)) send_beat(CH_SPACE, 1'b0);
                end else if (r < 92) begin
                    send_beat(CH_NEWLINE, 1'b0);
                end else begin
                    send_beat(pick_noise_byte(), 1'b0);
                end
            end
            if (shape == SHAPE_BROKEN) begin
                // open a string and either leave it open or break it with a newline
                send_beat(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 4)) send_beat(pick_text_byte(1'b0, 1'b1), 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    send_beat(CH_NEWLINE, 1'b0);
                    repeat ($urandom_range(0, 6)) send_beat(pick_noise_byte(), 1'b0);
                end
            end
        end
        send_end();
    endtask

    // Stimulus sequence
    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ch          = 8'h00;
        i_end_of_text = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: quote inside a word, semicolon in a string, comment, zero and top bytes,
        // end inside a word, end inside a string, newline in a string, empty text
        send_str("a\"b \"s;t\";c\n");
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_end();
        send_str("\"o");
        send_end();
        send_str("\"\nz");
        send_end();
        send_end();
        wait_results();

        // Hold the receiver off while words keep coming, so the input stalls
        fast_mode = 1'b1;
        hold_req  = 60;
        send_str("a b c d e f g h i j k l m n ");
        send_end();
        fast_mode = 1'b0;
        wait_results();

        // Random texts, with occasional drains and holds
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                fast_mode = 1'b1;
                hold_req  = $urandom_range(20, 80);
            end
            send_random_text();
            fast_mode = 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                wait_results();
            end
        end
        wait_results();

        // Saturate length, column, offset, then row
        fast_mode = 1'b1;
        send_beat(pick_text_byte(1'b1, 1'b1), 1'b0);
        repeat (SAT_RUN) send_beat(pick_text_byte(1'b1, 1'b0), 1'b0);
        send_beat(CH_SPACE, 1'b0);
        send_str("ab;");
        repeat (SAT_RUN) send_beat(CH_NEWLINE, 1'b0);
        send_str("x \"qq\" \"open");
        send_end();
        fast_mode = 1'b0;

        // Drain, then allow stray beats to show up
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.n_fail == 0 && sb.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
